// ----- sv/fds_pkg.sv -----
// ============================================================================
// fds_pkg
// Shared types, constants and helpers for the field difference statistics
// block: queue entry layout, pair classes, register indexes, back-end states.
// ============================================================================
package fds_pkg;

    // Register indexes on the configuration port
    localparam logic [1:0] REG_MISSING_A   = 2'd0;
    localparam logic [1:0] REG_MISSING_B   = 2'd1;
    localparam logic [1:0] REG_ABS_THRESH  = 2'd2;
    localparam logic [1:0] REG_REL_THRESH  = 2'd3;

    // Register reset values
    localparam logic [31:0] MISSING_RESET    = 32'h8000_0000;
    localparam logic [31:0] ABS_THRESH_RESET = 32'd66;
    localparam logic [16:0] REL_THRESH_RESET = 17'd66;

    // Field limits
    localparam int          FIELD17_MAX = 131071;
    localparam logic [16:0] REL_ONE     = 17'd65536;

    // Divider: one quotient bit per cycle, sixteen bits of Q0.16
    localparam int DIV_STEPS  = 16;
    localparam int STEP_WIDTH = $clog2(DIV_STEPS);

    // Queue between front and back
    localparam int QUEUE_DEPTH = 2;

    // Class of one sample pair, decided in the front end
    typedef enum logic [2:0] {
        KIND_BOTH_ABSENT,
        KIND_ONE_ABSENT,
        KIND_SIGN_FLIP,
        KIND_ZERO,
        KIND_RATIO
    } pair_kind_t;

    // One queued pair after classification
    typedef struct packed {
        pair_kind_t  kind;
        logic        last;
        logic [31:0] abs_diff;   // |a - b|
        logic [31:0] divisor;    // max(|a|, |b|)
    } fds_entry_t;

    // Queue status seen by both ends
    typedef struct packed {
        logic full;
        logic empty;
    } fds_queue_status_t;

    // Back-end sequencer states
    typedef enum logic [1:0] {
        BK_IDLE,
        BK_DIV,
        BK_APPLY
    } back_state_t;

    // Saturating record tally increment
    function automatic logic [15:0] tally_up(input logic [15:0] t);
        tally_up = (t == 16'hFFFF) ? t : t + 16'd1;
    endfunction

endpackage

// ----- sv/fds_front.sv -----
// ============================================================================
// fds_front
// Accepts sample pairs, checks them against the missing codes and sorts them
// into pair classes with their absolute difference and divisor.
// ============================================================================
module fds_front
    import fds_pkg::*;
(
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [31:0]       sample_a,
    input  logic [31:0]       sample_b,
    input  logic              last_of_record,
    input  logic [31:0]       missing_a,
    input  logic [31:0]       missing_b,
    input  fds_queue_status_t q_status,
    output logic              push,
    output fds_entry_t        push_entry
);

    logic        a_absent;
    logic        b_absent;
    logic [32:0] diff_wide;
    logic [32:0] diff_neg;
    logic [31:0] abs_diff;
    logic [31:0] mag_a;
    logic [31:0] mag_b;
    logic        a_zero;
    logic        b_zero;
    logic        a_pos;
    logic        b_pos;
    logic        flip;

    // Stall while the queue is full
    assign in_stall = q_status.full;
    assign push     = in_valid && !q_status.full;

    // Absent detection is exact bit equality
    assign a_absent = (sample_a == missing_a);
    assign b_absent = (sample_b == missing_b);

    // Absolute difference in 33 bits, magnitude fits 32
    assign diff_wide = {sample_a[31], sample_a} - {sample_b[31], sample_b};
    assign diff_neg  = 33'd0 - diff_wide;
    assign abs_diff  = diff_wide[32] ? diff_neg[31:0] : diff_wide[31:0];

    // Magnitudes; the most negative code maps to 2^31
    assign mag_a = sample_a[31] ? (~sample_a + 32'd1) : sample_a;
    assign mag_b = sample_b[31] ? (~sample_b + 32'd1) : sample_b;

    assign a_zero = (sample_a == 32'd0);
    assign b_zero = (sample_b == 32'd0);
    assign a_pos  = !sample_a[31] && !a_zero;
    assign b_pos  = !sample_b[31] && !b_zero;
    assign flip   = (sample_a[31] && b_pos) || (a_pos && sample_b[31]);

    // Classify the pair
    always_comb
    begin
        push_entry.last     = last_of_record;
        push_entry.abs_diff = abs_diff;
        push_entry.divisor  = (mag_a > mag_b) ? mag_a : mag_b;
        if (a_absent && b_absent)
            push_entry.kind = KIND_BOTH_ABSENT;
        else if (a_absent || b_absent)
            push_entry.kind = KIND_ONE_ABSENT;
        else if (flip)
            push_entry.kind = KIND_SIGN_FLIP;
        else if (a_zero || b_zero)
            push_entry.kind = KIND_ZERO;
        else
            push_entry.kind = KIND_RATIO;
    end

endmodule

// ----- sv/fds_queue.sv -----
// ============================================================================
// fds_queue
// Short FIFO of classified pairs between the front end and the back end.
// ============================================================================
module fds_queue
    import fds_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  fds_entry_t        push_entry,
    input  logic              pop,
    output fds_entry_t        head,
    output fds_queue_status_t status
);

    localparam int PTR_WIDTH = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_WIDTH = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PTR_WIDTH-1:0] PTR_LAST = PTR_WIDTH'(QUEUE_DEPTH - 1);
    localparam logic [CNT_WIDTH-1:0] CNT_FULL = CNT_WIDTH'(QUEUE_DEPTH);

    fds_entry_t           slot_reg [QUEUE_DEPTH];
    logic [PTR_WIDTH-1:0] wr_ptr_reg;
    logic [PTR_WIDTH-1:0] wr_ptr_next;
    logic [PTR_WIDTH-1:0] rd_ptr_reg;
    logic [PTR_WIDTH-1:0] rd_ptr_next;
    logic [CNT_WIDTH-1:0] count_reg;
    logic [CNT_WIDTH-1:0] count_next;

    assign status.full  = (count_reg == CNT_FULL);
    assign status.empty = (count_reg == '0);
    assign head         = slot_reg[rd_ptr_reg];

    // Advance pointers and fill level
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the pushed beat
    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= push_entry;
    end

endmodule

// ----- sv/fds_back.sv -----
// ============================================================================
// fds_back
// Takes classified pairs from the queue, runs the serial ratio divider when
// needed, folds each pair into the record statistics and emits the result
// beat on the last pair of a record.
// ============================================================================
module fds_back
    import fds_pkg::*;
#(
    parameter int MAX_POINTS = 65536
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  fds_queue_status_t q_status,
    input  fds_entry_t        q_head,
    output logic              pop,
    input  logic [31:0]       abs_threshold,
    input  logic [16:0]       rel_threshold,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [16:0]       differing_count,
    output logic [31:0]       max_abs_diff,
    output logic [16:0]       max_rel_diff,
    output logic              sign_flip_seen,
    output logic              zero_seen,
    output logic [15:0]       records_seen,
    output logic [15:0]       records_differing,
    output logic [15:0]       records_beyond_threshold
);

    localparam logic [16:0] DIFF_CAP =
        17'((MAX_POINTS > FIELD17_MAX) ? FIELD17_MAX : MAX_POINTS);
    localparam logic [STEP_WIDTH-1:0] STEP_LAST = STEP_WIDTH'(DIV_STEPS - 1);

    back_state_t state_reg;
    back_state_t state_next;

    fds_entry_t            work_reg;
    logic [31:0]           rem_reg;
    logic [31:0]           rem_next;
    logic [DIV_STEPS-1:0]  quo_reg;
    logic [DIV_STEPS-1:0]  quo_next;
    logic [STEP_WIDTH-1:0] step_reg;
    logic [32:0]           rem_shift;
    logic                  div_active;

    logic [16:0] cnt_reg;
    logic [31:0] abs_reg;
    logic [16:0] rel_reg;
    logic        sign_reg;
    logic        zero_reg;
    logic [15:0] rec_tally_reg;
    logic [15:0] diff_tally_reg;
    logic [15:0] beyond_tally_reg;

    logic        count_hit;
    logic [16:0] cnt_upd;
    logic [31:0] abs_upd;
    logic [16:0] rel_upd;
    logic        sign_upd;
    logic        zero_upd;
    logic [16:0] ratio;
    logic        apply_hold;
    logic        apply_fire;
    logic        emit;
    logic [15:0] diff_tally_upd;
    logic [15:0] beyond_tally_upd;

    logic        out_valid_reg;
    logic [16:0] out_count_reg;
    logic [31:0] out_abs_reg;
    logic [16:0] out_rel_reg;
    logic        out_sign_reg;
    logic        out_zero_reg;
    logic [15:0] out_rec_reg;
    logic [15:0] out_diff_reg;
    logic [15:0] out_beyond_reg;

    // Hold the last pair while the previous result beat is still waiting
    assign apply_hold = work_reg.last && out_valid_reg && out_stall;

    // Sequencer next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            BK_IDLE:
                if (!q_status.empty)
                    state_next = (q_head.kind == KIND_RATIO) ? BK_DIV : BK_APPLY;
            BK_DIV:
                if (step_reg == STEP_LAST)
                    state_next = BK_APPLY;
            BK_APPLY:
                if (!apply_hold)
                    state_next = BK_IDLE;
            default:
                state_next = BK_IDLE;
        endcase
    end

    // Sequencer outputs
    always_comb
    begin
        pop        = 1'b0;
        div_active = 1'b0;
        apply_fire = 1'b0;
        unique case (state_reg)
            BK_IDLE:  pop        = !q_status.empty;
            BK_DIV:   div_active = 1'b1;
            BK_APPLY: apply_fire = !apply_hold;
            default:  pop        = 1'b0;
        endcase
    end

    assign emit = apply_fire && work_reg.last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= BK_IDLE;
        else
            state_reg <= state_next;
    end

    // Restoring divider step: remainder stays below the divisor
    assign rem_shift = {rem_reg, 1'b0};

    always_comb
    begin
        if (rem_shift >= {1'b0, work_reg.divisor})
        begin
            rem_next = 32'(rem_shift - {1'b0, work_reg.divisor});
            quo_next = {quo_reg[DIV_STEPS-2:0], 1'b1};
        end
        else
        begin
            rem_next = rem_shift[31:0];
            quo_next = {quo_reg[DIV_STEPS-2:0], 1'b0};
        end
    end

    // Load the popped beat and run the divider
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            work_reg <= q_head;
            rem_reg  <= q_head.abs_diff;
            quo_reg  <= '0;
        end
        else if (div_active)
        begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            step_reg <= '0;
        else if (pop)
            step_reg <= '0;
        else if (div_active)
            step_reg <= step_reg + 1'b1;
    end

    // Quotient of same-signed nonzero samples is below 1.0
    assign ratio = 17'(quo_reg);

    // Fold the current pair into the record statistics
    always_comb
    begin
        count_hit = 1'b0;
        abs_upd   = abs_reg;
        rel_upd   = rel_reg;
        case (work_reg.kind) inside
            KIND_ONE_ABSENT:
            begin
                count_hit = 1'b1;
                rel_upd   = REL_ONE;
            end
            KIND_SIGN_FLIP, KIND_ZERO, KIND_RATIO:
            begin
                count_hit = (work_reg.abs_diff != 32'd0);
                if (work_reg.abs_diff > abs_reg)
                    abs_upd = work_reg.abs_diff;
                if (work_reg.kind == KIND_RATIO && ratio > rel_reg)
                    rel_upd = ratio;
            end
            default:
                count_hit = 1'b0;
        endcase
        cnt_upd  = (count_hit && cnt_reg < DIFF_CAP) ? cnt_reg + 17'd1 : cnt_reg;
        sign_upd = sign_reg || (work_reg.kind == KIND_SIGN_FLIP);
        zero_upd = zero_reg || (work_reg.kind == KIND_ZERO);
    end

    // Record tallies on the last pair
    always_comb
    begin
        diff_tally_upd   = diff_tally_reg;
        beyond_tally_upd = beyond_tally_reg;
        if (abs_upd != 32'd0 || rel_upd != 17'd0)
            diff_tally_upd = tally_up(diff_tally_reg);
        if (abs_upd > abs_threshold || rel_upd > rel_threshold)
            beyond_tally_upd = tally_up(beyond_tally_reg);
    end

    // Update or clear the record statistics
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg          <= '0;
            abs_reg          <= '0;
            rel_reg          <= '0;
            sign_reg         <= 1'b0;
            zero_reg         <= 1'b0;
            rec_tally_reg    <= '0;
            diff_tally_reg   <= '0;
            beyond_tally_reg <= '0;
        end
        else if (apply_fire)
        begin
            if (work_reg.last)
            begin
                cnt_reg          <= '0;
                abs_reg          <= '0;
                rel_reg          <= '0;
                sign_reg         <= 1'b0;
                zero_reg         <= 1'b0;
                rec_tally_reg    <= tally_up(rec_tally_reg);
                diff_tally_reg   <= diff_tally_upd;
                beyond_tally_reg <= beyond_tally_upd;
            end
            else
            begin
                cnt_reg  <= cnt_upd;
                abs_reg  <= abs_upd;
                rel_reg  <= rel_upd;
                sign_reg <= sign_upd;
                zero_reg <= zero_upd;
            end
        end
    end

    // Result beat valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (emit)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    // Result beat payload
    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            out_count_reg  <= cnt_upd;
            out_abs_reg    <= abs_upd;
            out_rel_reg    <= rel_upd;
            out_sign_reg   <= sign_upd;
            out_zero_reg   <= zero_upd;
            out_rec_reg    <= tally_up(rec_tally_reg);
            out_diff_reg   <= diff_tally_upd;
            out_beyond_reg <= beyond_tally_upd;
        end
    end

    assign out_valid                = out_valid_reg;
    assign differing_count          = out_count_reg;
    assign max_abs_diff             = out_abs_reg;
    assign max_rel_diff             = out_rel_reg;
    assign sign_flip_seen           = out_sign_reg;
    assign zero_seen                = out_zero_reg;
    assign records_seen             = out_rec_reg;
    assign records_differing        = out_diff_reg;
    assign records_beyond_threshold = out_beyond_reg;

endmodule

// ----- sv/field_difference_statistics.sv -----
// ============================================================================
// field_difference_statistics
// Per-record comparison statistics of two streams of Q16.16 sample pairs.
// ============================================================================
// Each input beat is one pair; a pair is absent on a side when its bits equal
// that side's missing code. The front end classifies a pair in the cycle it
// is accepted and drops it into a two-entry queue. The back end takes one
// pair at a time: a pair whose relative difference must be computed is
// popped, run through the one-bit-per-cycle restoring divider and then
// applied to the record; every other pair is popped and applied. The divider
// sets the sustained rate. A result beat appears on the pair marked last and
// sits in an output register, so the queue keeps filling while it waits.
// Configuration writes take effect at once and should be made while idle.
module field_difference_statistics
    import fds_pkg::*;
#(
    parameter int MAX_POINTS = 65536
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_write_en,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [31:0] sample_a,
    input  logic [31:0] sample_b,
    input  logic        last_of_record,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [16:0] differing_count,
    output logic [31:0] max_abs_diff,
    output logic [16:0] max_rel_diff,
    output logic        sign_flip_seen,
    output logic        zero_seen,
    output logic [15:0] records_seen,
    output logic [15:0] records_differing,
    output logic [15:0] records_beyond_threshold
);

    logic [31:0] missing_a_reg;
    logic [31:0] missing_b_reg;
    logic [31:0] abs_thresh_reg;
    logic [16:0] rel_thresh_reg;

    fds_queue_status_t q_status;
    fds_entry_t        push_entry;
    fds_entry_t        q_head;
    logic              push;
    logic              pop;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            missing_a_reg  <= MISSING_RESET;
            missing_b_reg  <= MISSING_RESET;
            abs_thresh_reg <= ABS_THRESH_RESET;
            rel_thresh_reg <= REL_THRESH_RESET;
        end
        else if (cfg_write_en)
        begin
            unique case (cfg_index)
                REG_MISSING_A:  missing_a_reg  <= cfg_data;
                REG_MISSING_B:  missing_b_reg  <= cfg_data;
                REG_ABS_THRESH: abs_thresh_reg <= cfg_data;
                REG_REL_THRESH: rel_thresh_reg <= cfg_data[16:0];
                default:        missing_a_reg  <= missing_a_reg;
            endcase
        end
    end

    fds_front u_front (
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .sample_a       (sample_a),
        .sample_b       (sample_b),
        .last_of_record (last_of_record),
        .missing_a      (missing_a_reg),
        .missing_b      (missing_b_reg),
        .q_status       (q_status),
        .push           (push),
        .push_entry     (push_entry)
    );

    fds_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .head       (q_head),
        .status     (q_status)
    );

    fds_back #(
        .MAX_POINTS (MAX_POINTS)
    ) u_back (
        .clk                      (clk),
        .rst_n                    (rst_n),
        .q_status                 (q_status),
        .q_head                   (q_head),
        .pop                      (pop),
        .abs_threshold            (abs_thresh_reg),
        .rel_threshold            (rel_thresh_reg),
        .out_valid                (out_valid),
        .out_stall                (out_stall),
        .differing_count          (differing_count),
        .max_abs_diff             (max_abs_diff),
        .max_rel_diff             (max_rel_diff),
        .sign_flip_seen           (sign_flip_seen),
        .zero_seen                (zero_seen),
        .records_seen             (records_seen),
        .records_differing        (records_differing),
        .records_beyond_threshold (records_beyond_threshold)
    );

endmodule

// ----- sv/fds_checker.sv -----
// ============================================================================
// fds_checker
// Port-level checks on the result channel of field_difference_statistics.
// ============================================================================
module fds_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_stall,
    input logic [16:0] differing_count,
    input logic [31:0] max_abs_diff,
    input logic [16:0] max_rel_diff,
    input logic [15:0] records_seen,
    input logic [15:0] records_differing,
    input logic [15:0] records_beyond_threshold
);

    // A stalled result beat stays up
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result beat dropped while stalled");

    // Tallied records never outnumber finished records
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (records_differing <= records_seen)
                   && (records_beyond_threshold <= records_seen))
        else $error("record tally exceeds records seen");

    // Relative maximum never passes 1.0
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> max_rel_diff <= 17'd65536)
        else $error("relative maximum above 1.0");

    // A record with no counted pair has no difference at all
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && differing_count == 17'd0
            |-> max_abs_diff == 32'd0 && max_rel_diff == 17'd0)
        else $error("difference reported with zero differing count");

endmodule

bind field_difference_statistics fds_checker u_fds_checker (
    .clk                      (clk),
    .rst_n                    (rst_n),
    .out_valid                (out_valid),
    .out_stall                (out_stall),
    .differing_count          (differing_count),
    .max_abs_diff             (max_abs_diff),
    .max_rel_diff             (max_rel_diff),
    .records_seen             (records_seen),
    .records_differing        (records_differing),
    .records_beyond_threshold (records_beyond_threshold)
);
